// ----- hw/rtl/bba_pkg.sv -----
// Shared types and constants of the buddy block allocator.
// Used by bba_ctrl, bba_dp and buddy_block_allocator; depends on nothing.
package bba_pkg;

    // Default geometry of the pool.
    localparam int P_MAX_ORDER    = 16;
    localparam int P_HEADER_BYTES = 48;
    localparam int P_MIN_ORDER    = 6;

    // Result status codes.
    typedef logic [1:0] t_status;
    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_IGNORED = 2'd1;
    localparam t_status ST_NOMEM   = 2'd2;
    localparam t_status ST_RANGE   = 2'd3;

    // Controller states.
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_WRD, S_WEV, S_WEND, S_SPLIT,
        S_AFIN, S_FEV, S_MCHK, S_MEV, S_FFIN, S_DONE
    } t_state;

    // Datapath operations.
    typedef enum logic [3:0] {
        OP_NONE, OP_LATCH, OP_CLEAR, OP_WALK_RD, OP_WALK_EV, OP_SPLIT,
        OP_AFINAL, OP_FREE_RD, OP_FREE_EV, OP_MERGE_RD, OP_MERGE_EV,
        OP_FFINAL, OP_ERR, OP_DELIVER
    } t_op;

    // Command from controller to datapath.
    typedef struct packed {
        t_op     op;
        t_status err;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic is_free;
        logic null_ptr;
        logic zero_size;
        logic too_big;
        logic bad_off;
        logic walk_end;
        logic found;
        logic need_split;
        logic split_last;
        logic tag_res;
        logic o_lt_max;
        logic buddy_match;
        logic clear_last;
        logic out_busy;
    } t_stat;

endpackage

// ----- hw/rtl/bba_ram.sv -----
// Generic simple dual-port RAM with registered read.
// Used for the granule tag store; depends on nothing.
module bba_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // One write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

// ----- hw/rtl/bba_dp.sv -----
// Datapath of the buddy block allocator: request registers, block walk,
// split and merge arithmetic, tag RAM and the output register.
// Depends on bba_pkg and bba_ram.
module bba_dp
    import bba_pkg::*;
#(
    parameter int MAX_ORDER    = P_MAX_ORDER,
    parameter int HEADER_BYTES = P_HEADER_BYTES,
    parameter int MIN_ORDER    = P_MIN_ORDER
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [39:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic        i_m_tready,
    output logic        o_m_tvalid,
    output logic [23:0] o_m_tdata
);

    localparam int GW    = MAX_ORDER - MIN_ORDER;
    localparam int NGRAN = 1 << GW;
    localparam int SW    = (MAX_ORDER >= 17) ? MAX_ORDER + 1 : 18;
    localparam int OW    = SW + 9;

    // Request registers.
    logic          r_req_free;
    logic          r_null;
    logic [16:0]   r_size;
    logic [15:0]   r_off;
    // Walk pointer / clear counter, current block and order.
    logic [GW:0]   r_ptr;
    logic [GW-1:0] r_g;
    logic [4:0]    r_o;
    logic          r_found;
    // Result being built and output register.
    logic [15:0]   r_res_off;
    logic [4:0]    r_res_ord;
    t_status       r_res_st;
    logic          r_out_valid;
    logic [23:0]   r_out_data;

    // RAM port signals.
    logic          w_we;
    logic [GW-1:0] w_waddr;
    logic [5:0]    w_wdata;
    logic          w_re;
    logic [GW-1:0] w_raddr;
    logic [5:0]    w_q;

    function automatic logic [4:0] f_bitlen(input logic [17:0] v);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 18; i++) begin
            if (v[i]) begin
                n = 5'(i + 1);
            end
        end
        return n;
    endfunction

    // Order needed by an allocate request.
    logic [17:0] w_need;
    logic [4:0]  w_kraw;
    logic [4:0]  w_k;
    assign w_need = 18'(r_size) + 18'(HEADER_BYTES);
    assign w_kraw = f_bitlen(w_need - 18'd1);
    assign w_k    = (w_kraw < 5'(MIN_ORDER)) ? 5'(MIN_ORDER) : w_kraw;

    // Free offset decode.
    logic [SW-1:0] w_seg;
    logic          w_bad_off;
    logic [GW-1:0] w_fg;
    assign w_seg     = SW'(r_off) - SW'(HEADER_BYTES);
    assign w_bad_off = (r_off < 16'(HEADER_BYTES))
                    || (w_seg >= (SW'(1) << MAX_ORDER))
                    || (w_seg[MIN_ORDER-1:0] != '0);
    assign w_fg      = w_seg[MIN_ORDER +: GW];

    // Block walk: step from one block head to the next.
    logic [4:0]  w_q_ord;
    logic [GW:0] w_ptr_nxt;
    logic        w_better;
    assign w_q_ord   = w_q[4:0];
    assign w_ptr_nxt = r_ptr + ((GW+1)'(1) << (w_q_ord - 5'(MIN_ORDER)));
    assign w_better  = !w_q[5] && (w_q_ord >= w_k) && (!r_found || (w_q_ord < r_o));

    // Split and merge addresses.
    logic [4:0]    w_o_dn;
    logic [GW-1:0] w_sbud;
    logic [GW-1:0] w_bit;
    logic [OW-1:0] w_aoff;
    assign w_o_dn = r_o - 5'd1;
    assign w_sbud = r_g + (GW'(1) << (w_o_dn - 5'(MIN_ORDER)));
    assign w_bit  = GW'(1) << (r_o - 5'(MIN_ORDER));
    assign w_aoff = (OW'(r_g) << MIN_ORDER) + OW'(HEADER_BYTES);

    // RAM access for each operation.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_g;
        w_wdata = 6'd0;
        w_re    = 1'b0;
        w_raddr = r_ptr[GW-1:0];
        case (i_cmd.op)
            OP_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_ptr[GW-1:0];
                w_wdata = (r_ptr == '0) ? 6'(MAX_ORDER) : 6'd0;
            end
            OP_WALK_RD: begin
                w_re = 1'b1;
            end
            OP_SPLIT: begin
                w_we    = 1'b1;
                w_waddr = w_sbud;
                w_wdata = {1'b0, w_o_dn};
            end
            OP_AFINAL: begin
                w_we    = 1'b1;
                w_wdata = {1'b1, w_k};
            end
            OP_FREE_RD: begin
                w_re    = 1'b1;
                w_raddr = w_fg;
            end
            OP_MERGE_RD: begin
                w_re    = 1'b1;
                w_raddr = r_g ^ w_bit;
            end
            OP_MERGE_EV: begin
                w_we    = 1'b1;
                w_waddr = r_g | w_bit;
            end
            OP_FFINAL: begin
                w_we    = 1'b1;
                w_wdata = {1'b0, r_o};
            end
            default: begin
            end
        endcase
    end

    bba_ram #(
        .WIDTH(6),
        .DEPTH(NGRAN)
    ) u_tag_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_q)
    );

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_found <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_LATCH: begin
                    r_size     <= i_s_tdata[16:0];
                    r_off      <= i_s_tdata[32:17];
                    r_req_free <= i_s_tuser[0];
                    r_null     <= i_s_tuser[1];
                    r_ptr      <= '0;
                    r_found    <= 1'b0;
                end
                OP_CLEAR: begin
                    r_ptr <= r_ptr + (GW+1)'(1);
                end
                OP_WALK_EV: begin
                    if (w_better) begin
                        r_found <= 1'b1;
                        r_g     <= r_ptr[GW-1:0];
                        r_o     <= w_q_ord;
                    end
                    r_ptr <= w_ptr_nxt;
                end
                OP_SPLIT: begin
                    r_o <= w_o_dn;
                end
                OP_AFINAL: begin
                    r_res_off <= w_aoff[15:0];
                    r_res_ord <= w_k;
                    r_res_st  <= ST_OK;
                end
                OP_FREE_RD: begin
                    r_g <= w_fg;
                end
                OP_FREE_EV: begin
                    r_o <= w_q[4:0];
                end
                OP_MERGE_EV: begin
                    r_g <= r_g & ~w_bit;
                    r_o <= r_o + 5'd1;
                end
                OP_FFINAL: begin
                    r_res_off <= 16'd0;
                    r_res_ord <= r_o;
                    r_res_st  <= ST_OK;
                end
                OP_ERR: begin
                    r_res_off <= 16'd0;
                    r_res_ord <= 5'd0;
                    r_res_st  <= i_cmd.err;
                end
                OP_DELIVER: begin
                    r_out_data <= {1'b0, r_res_st, r_res_ord, r_res_off};
                end
                default: begin
                end
            endcase
        end
    end

    // Output valid: set when a result is delivered, cleared when it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_DELIVER) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Status toward the controller.
    always_comb begin
        o_stat.is_free     = r_req_free;
        o_stat.null_ptr    = r_null;
        o_stat.zero_size   = (r_size == 17'd0);
        o_stat.too_big     = (w_k > 5'(MAX_ORDER));
        o_stat.bad_off     = w_bad_off;
        o_stat.walk_end    = w_ptr_nxt[GW];
        o_stat.found       = r_found;
        o_stat.need_split  = (r_o > w_k);
        o_stat.split_last  = (w_o_dn == w_k);
        o_stat.tag_res     = w_q[5];
        o_stat.o_lt_max    = (r_o < 5'(MAX_ORDER));
        o_stat.buddy_match = (w_q == {1'b0, r_o});
        o_stat.clear_last  = (r_ptr[GW-1:0] == '1);
        o_stat.out_busy    = r_out_valid && !i_m_tready;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ----- hw/rtl/bba_ctrl.sv -----
// Controller state machine of the buddy block allocator.
// Depends on bba_pkg; drives the datapath through t_cmd and reads t_stat.
module bba_ctrl
    import bba_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_NONE;
        o_cmd.err  = ST_OK;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_stat.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.op = OP_LATCH;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_stat.is_free) begin
                    if (i_stat.zero_size) begin
                        o_cmd.op  = OP_ERR;
                        o_cmd.err = ST_IGNORED;
                        n_state   = S_DONE;
                    end else if (i_stat.too_big) begin
                        o_cmd.op  = OP_ERR;
                        o_cmd.err = ST_NOMEM;
                        n_state   = S_DONE;
                    end else begin
                        n_state = S_WRD;
                    end
                end else if (i_stat.null_ptr) begin
                    o_cmd.op  = OP_ERR;
                    o_cmd.err = ST_IGNORED;
                    n_state   = S_DONE;
                end else if (i_stat.bad_off) begin
                    o_cmd.op  = OP_ERR;
                    o_cmd.err = ST_RANGE;
                    n_state   = S_DONE;
                end else begin
                    o_cmd.op = OP_FREE_RD;
                    n_state  = S_FEV;
                end
            end
            S_WRD: begin
                o_cmd.op = OP_WALK_RD;
                n_state  = S_WEV;
            end
            S_WEV: begin
                o_cmd.op = OP_WALK_EV;
                n_state  = i_stat.walk_end ? S_WEND : S_WRD;
            end
            S_WEND: begin
                if (!i_stat.found) begin
                    o_cmd.op  = OP_ERR;
                    o_cmd.err = ST_NOMEM;
                    n_state   = S_DONE;
                end else begin
                    n_state = i_stat.need_split ? S_SPLIT : S_AFIN;
                end
            end
            S_SPLIT: begin
                o_cmd.op = OP_SPLIT;
                if (i_stat.split_last) n_state = S_AFIN;
            end
            S_AFIN: begin
                o_cmd.op = OP_AFINAL;
                n_state  = S_DONE;
            end
            S_FEV: begin
                if (!i_stat.tag_res) begin
                    o_cmd.op  = OP_ERR;
                    o_cmd.err = ST_RANGE;
                    n_state   = S_DONE;
                end else begin
                    o_cmd.op = OP_FREE_EV;
                    n_state  = S_MCHK;
                end
            end
            S_MCHK: begin
                if (i_stat.o_lt_max) begin
                    o_cmd.op = OP_MERGE_RD;
                    n_state  = S_MEV;
                end else begin
                    n_state = S_FFIN;
                end
            end
            S_MEV: begin
                if (i_stat.buddy_match) begin
                    o_cmd.op = OP_MERGE_EV;
                    n_state  = S_MCHK;
                end else begin
                    n_state = S_FFIN;
                end
            end
            S_FFIN: begin
                o_cmd.op = OP_FFINAL;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = OP_DELIVER;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // A split only runs while the block is still larger than the target.
    a_split_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPLIT) |-> i_stat.need_split)
        else $error("split entered without a larger block");

    // A walk that found nothing ends in an out-of-memory result.
    a_walk_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WEND && !i_stat.found) |=> (r_state == S_DONE))
        else $error("failed walk did not report");

    // An accepted request always goes to the check step.
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_s_tvalid) |=> (r_state == S_CHECK))
        else $error("accepted request not checked");

    // A merge step is only taken when the order is below the pool order.
    a_merge_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_MERGE_RD) |-> i_stat.o_lt_max)
        else $error("merge beyond the pool order");
`endif

endmodule

// ----- hw/rtl/buddy_block_allocator.sv -----
// Top level of the buddy block allocator: controller plus datapath.
// Depends on bba_pkg, bba_ctrl, bba_dp (and bba_ram below it).
//
//  Channel   Dir  Ports                        Carries
//  s_axis    in   i_s_tvalid/o_s_tready        one allocate or free request
//  m_axis    out  o_m_tvalid/i_m_tready        one result per request
//
// An allocate walks the pool one block head per tag RAM read, then splits the
// found block one order per split step until it fits the request.
// A free reads the block's tag, then merges one buddy level per tag RAM read.
// After reset a clearing pass writes all 2^(MAX_ORDER-MIN_ORDER) tag RAM
// entries with o_s_tready low. A waiting result does not block the next request;
// a second finished result waits in the datapath until the output drains.
module buddy_block_allocator
    import bba_pkg::*;
#(
    parameter int MAX_ORDER    = P_MAX_ORDER,
    parameter int HEADER_BYTES = P_HEADER_BYTES,
    parameter int MIN_ORDER    = P_MIN_ORDER
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [16:0] alloc_size, [32:17] free_offset, [39:33] zero
    input  logic [39:0] i_s_tdata,
    // [0] req_type, [1] null_pointer
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [15:0] data_offset, [20:16] granted_order, [22:21] status, [23] zero
    output logic [23:0] o_m_tdata
);

    t_cmd  w_cmd;
    t_stat w_stat;

    bba_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    bba_dp #(
        .MAX_ORDER   (MAX_ORDER),
        .HEADER_BYTES(HEADER_BYTES),
        .MIN_ORDER   (MIN_ORDER)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .i_cmd     (w_cmd),
        .o_stat    (w_stat),
        .i_m_tready(i_m_tready),
        .o_m_tvalid(o_m_tvalid),
        .o_m_tdata (o_m_tdata)
    );

endmodule

// ----- tb/bba_checker.sv -----
// Checker for the buddy block allocator: watches both stream channels,
// predicts each result from its own pool model and compares. Depends on bba_pkg.
`timescale 1ns / 100ps

module bba_checker
    import bba_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int NGRAN   = 1 << (P_MAX_ORDER - P_MIN_ORDER);
    localparam logic [5:0] RESERVED = 6'd32;

    // Fields from the top bit down, matching the result bus layout.
    typedef struct packed {
        t_status     status;
        logic [4:0]  granted_order;
        logic [15:0] data_offset;
    } t_result;

    logic [5:0] pool_tag [NGRAN];
    t_result    expected_results [$];

    // Grant the lowest free block of the smallest sufficient order.
    function automatic t_result allocate_block(input logic [16:0] size);
        t_result r;
        int need;
        int k;
        int g;
        int o;
        r = '0;
        if (size == 0) begin
            r.status = ST_IGNORED;
            return r;
        end
        need = int'(size) + P_HEADER_BYTES;
        k = 0;
        while ((1 << k) < need) k++;
        if (k < P_MIN_ORDER) k = P_MIN_ORDER;
        r.status = ST_NOMEM;
        if (k > P_MAX_ORDER) return r;
        for (o = k; o <= P_MAX_ORDER; o++) begin
            for (g = 0; g < NGRAN; g++) begin
                if (pool_tag[g] == 6'(o)) break;
            end
            if (g < NGRAN) begin
                while (o > k) begin
                    o--;
                    pool_tag[g] = 6'(o);
                    pool_tag[g + (1 << (o - P_MIN_ORDER))] = 6'(o);
                end
                pool_tag[g] = RESERVED | 6'(k);
                r.data_offset = 16'((g << P_MIN_ORDER) + P_HEADER_BYTES);
                r.granted_order = 5'(k);
                r.status = ST_OK;
                return r;
            end
        end
        return r;
    endfunction

    // Release a block and merge it with free buddies of equal order.
    function automatic t_result free_block(input logic [15:0] offset, input logic is_null);
        t_result r;
        int seg;
        int g;
        int o;
        int b;
        r = '0;
        if (is_null) begin
            r.status = ST_IGNORED;
            return r;
        end
        r.status = ST_RANGE;
        if (offset < P_HEADER_BYTES) return r;
        seg = int'(offset) - P_HEADER_BYTES;
        if (seg >= (1 << P_MAX_ORDER) || (seg % (1 << P_MIN_ORDER)) != 0) return r;
        g = seg >> P_MIN_ORDER;
        if (!pool_tag[g][5]) return r;
        o = pool_tag[g][4:0];
        pool_tag[g] = 6'(o);
        while (o < P_MAX_ORDER) begin
            b = g ^ (1 << (o - P_MIN_ORDER));
            if (pool_tag[b] != 6'(o)) break;
            pool_tag[b] = '0;
            pool_tag[g] = '0;
            if (b < g) g = b;
            o++;
            pool_tag[g] = 6'(o);
        end
        r.granted_order = 5'(o);
        r.status = ST_OK;
        return r;
    endfunction

    assign o_pending = expected_results.size();

    // Predict on each accepted request, compare on each accepted result.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < NGRAN; i++) pool_tag[i] = '0;
            pool_tag[0] = 6'(P_MAX_ORDER);
            expected_results.delete();
            o_fail_count <= 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got = t_result'(i_m_tdata[22:0]);
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got.data_offset != want.data_offset
                            || got.granted_order != want.granted_order
                            || got.status != want.status || i_m_tdata[23]) begin
                        $display({"%0t: result mismatch expected off=%h ord=%0d st=%0d,",
                                  " actual off=%h ord=%0d st=%0d"},
                                 $time, want.data_offset, want.granted_order, want.status,
                                 got.data_offset, got.granted_order, got.status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser[0])
                    expected_results.push_back(free_block(i_s_tdata[32:17], i_s_tuser[1]));
                else
                    expected_results.push_back(allocate_block(i_s_tdata[16:0]));
            end
        end
    end

endmodule

// ----- tb/tb_buddy_block_allocator.sv -----
// Testbench top for the buddy block allocator: drives requests with random
// gaps and stalls; bba_checker predicts and compares. Depends on bba_pkg.
`timescale 1ns / 100ps

module tb_buddy_block_allocator
    import bba_pkg::*;
();

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    int          fail_count;
    int          pending;
    logic        quiet;
    logic [15:0] live_offsets [$];

    buddy_block_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata)
    );

    bba_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Remember granted offsets so that most frees name a live block.
    always @(posedge i_clk) begin
        if (m_tvalid && m_tready && m_tdata[22:21] == ST_OK && m_tdata[15:0] != 0)
            live_offsets.push_back(m_tdata[15:0]);
    end

    // Result side stalls in random bursts.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
            m_tready <= 1'b1;
        end
    end

    // Present one request and hold it until accepted.
    task automatic send_request(input logic kind, input logic [16:0] size,
                                input logic [15:0] offset, input logic is_null);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, offset, size};
        s_tuser  <= {is_null, kind};
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic free_live(input int idx);
        logic [15:0] off;
        off = live_offsets[idx];
        live_offsets.delete(idx);
        send_request(REQ_FREE, 17'($urandom), off, 1'b0);
    endtask

    initial begin
        int sel;
        int wait_cycles;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        quiet    = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: special cases and field extremes.
        send_request(REQ_ALLOC, 17'd0, 16'hFFFF, 1'b1);
        send_request(REQ_ALLOC, 17'd65536, 16'd0, 1'b0);
        send_request(REQ_ALLOC, 17'h1FFFF, 16'd0, 1'b0);
        send_request(REQ_ALLOC, 17'd65488, 16'd0, 1'b0);
        send_request(REQ_ALLOC, 17'd65489, 16'd0, 1'b0);
        send_request(REQ_FREE, 17'd0, 16'd48, 1'b1);
        send_request(REQ_FREE, 17'd0, 16'd47, 1'b0);
        send_request(REQ_FREE, 17'd0, 16'd0, 1'b0);
        send_request(REQ_FREE, 17'd0, 16'hFFFF, 1'b0);
        send_request(REQ_FREE, 17'd0, 16'd49, 1'b0);
        send_request(REQ_ALLOC, 17'd1, 16'hFFFF, 1'b1);
        send_request(REQ_ALLOC, 17'd16, 16'd0, 1'b0);
        send_request(REQ_ALLOC, 17'd17, 16'd0, 1'b0);
        send_request(REQ_ALLOC, 17'd30000, 16'd0, 1'b0);
        send_request(REQ_ALLOC, 17'd30000, 16'd0, 1'b0);
        send_request(REQ_FREE, 17'd0, 16'd112, 1'b0);
        send_request(REQ_FREE, 17'd0, 16'd48, 1'b0);
        send_request(REQ_FREE, 17'd0, 16'd48, 1'b0);
        send_request(REQ_FREE, 17'd0, 16'hFFF0, 1'b0);

        // Random: mostly allocates and frees of live blocks, some noise.
        for (int n = 0; n < 700; n++) begin
            if (n > 620) quiet = 1'b1;
            sel = $urandom_range(0, 99);
            if (sel < 45)
                send_request(REQ_ALLOC, 17'($urandom_range(1, 1 << $urandom_range(2, 14))),
                             16'($urandom), 1'($urandom));
            else if (sel < 85 && live_offsets.size() > 0)
                free_live($urandom_range(0, live_offsets.size() - 1));
            else if (sel < 90)
                send_request(REQ_ALLOC, 17'($urandom), 16'($urandom), 1'($urandom));
            else if (sel < 95)
                send_request(REQ_FREE, 17'($urandom), 16'($urandom), 1'($urandom));
            else
                send_request(REQ_FREE, 17'($urandom),
                             16'(($urandom_range(0, 1023) << 6) + 48), 1'b0);
        end
        s_tvalid <= 1'b0;

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 200000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_buddy_block_allocator: clean");
        else
            $display("tb_buddy_block_allocator: errors");
        $finish;
    end

    // Generous limit covering the clearing pass and worst-case walks.
    initial begin
        #30000000;
        $display("tb_buddy_block_allocator: errors");
        $finish;
    end

endmodule

// ----- buddy_block_allocator.f -----
hw/rtl/bba_pkg.sv
hw/rtl/bba_ram.sv
hw/rtl/bba_dp.sv
hw/rtl/bba_ctrl.sv
hw/rtl/buddy_block_allocator.sv
tb/bba_checker.sv
tb/tb_buddy_block_allocator.sv
